// ===== src/llh_pkg.sv =====
// ----------------------------------------------------------------------------
// llh_pkg
// Shared types and constants for the log2 latency histogram: operation codes,
// field widths, the payload structs and the shared adder request/response.
// ----------------------------------------------------------------------------
package llh_pkg;

  // Default number of power-of-two buckets.
  localparam int LLH_BUCKETS = 64;

  // Fixed field widths.
  localparam int SAMPLE_W  = 64;
  localparam int CNT_W     = 32;
  localparam int QTL_W     = 10;
  localparam int SMP_IDX_W = 6;   // bit index of a 64-bit sample
  localparam int ALU_W     = 64;

  // Quantile scale (per-mille) and saturation value of the counters.
  localparam logic [QTL_W-1:0] PERMILLE_SCALE = 10'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;

  // Register index of limit_cycles on the configuration port.
  localparam logic LLH_REG_LIMIT = 1'b0;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } llh_op_t;

  // One input item.
  typedef struct packed {
    logic [1:0]          operation;
    logic [SAMPLE_W-1:0] sample_cycles;
    logic [QTL_W-1:0]    quantile_permille;
  } llh_in_t;

  // One result item.
  typedef struct packed {
    logic [SAMPLE_W-1:0] percentile_floor;
    logic [CNT_W-1:0]    count_above_limit;
    logic [CNT_W-1:0]    total_samples;
    logic [SAMPLE_W-1:0] sample_sum;
    logic [SAMPLE_W-1:0] largest_sample;
  } llh_out_t;

  // Request to the shared adder/subtractor.
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } llh_alu_req_t;

  // Response of the shared adder/subtractor; co is a >= b on a subtract.
  typedef struct packed {
    logic             co;
    logic [ALU_W-1:0] y;
  } llh_alu_rsp_t;

endpackage

// ===== src/log2_latency_histogram_top.sv =====
// ----------------------------------------------------------------------------
// log2_latency_histogram_top
// A record walks the states LOD, MAX, INC and CNT with busy high; a clear takes
// effect at once and leaves busy low. A query passes QSET, then PRD, PMUL and
// PACC for each bucket walked up to the selected one (none with no samples),
// then LSET and, when limit_cycles is nonzero, LRD and LACC for every bucket.
// Its result strobes in the first cycle with busy low; the receiver cannot stall the result.
// Synchronous active-low reset clears all statistics and limit_cycles.
// ----------------------------------------------------------------------------
module log2_latency_histogram_top
  import llh_pkg::*;
#(
  parameter int BUCKETS = LLH_BUCKETS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  llh_in_t     in_data,
  // Result channel
  output logic        out_valid,
  output llh_out_t    out_data,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = $clog2(BUCKETS);
  localparam int NQ_W   = CNT_W + QTL_W;
  localparam int ACC_W  = NQ_W + IDX_W;
  localparam int LCNT_W = CNT_W + IDX_W;
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(BUCKETS - 1);
  localparam logic [SMP_IDX_W:0] LAST_BKT = (SMP_IDX_W + 1)'(BUCKETS - 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LOD  = 12'b000000000010,
    S_MAX  = 12'b000000000100,
    S_INC  = 12'b000000001000,
    S_CNT  = 12'b000000010000,
    S_QSET = 12'b000000100000,
    S_PRD  = 12'b000001000000,
    S_PMUL = 12'b000010000000,
    S_PACC = 12'b000100000000,
    S_LSET = 12'b001000000000,
    S_LRD  = 12'b010000000000,
    S_LACC = 12'b100000000000
  } llh_state_t;

  // Highest nonzero byte of a 64-bit word.
  function automatic logic [2:0] msb_byte(input logic [SAMPLE_W-1:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (|v[8*i +: 8]) idx = 3'(i);
    end
    return idx;
  endfunction

  // Highest set bit of a byte.
  function automatic logic [2:0] msb_bit(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  llh_state_t          state_r, state_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [QTL_W-1:0]    qtl_r, qtl_nxt;
  logic [63:0]         limit_r, limit_nxt;
  logic [SAMPLE_W-1:0] sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [2:0]          byte_idx_r, byte_idx_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [IDX_W-1:0]    bkt_r, bkt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [NQ_W-1:0]     nq_r, nq_nxt;
  logic [NQ_W-1:0]     prod_r, prod_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [IDX_W-1:0]    pct_idx_r, pct_idx_nxt;
  logic                pct_zero_r, pct_zero_nxt;
  logic [SAMPLE_W-1:0] floor_r, floor_nxt;
  logic [LCNT_W-1:0]   lcnt_r, lcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  llh_out_t            out_data_r, out_data_nxt;

  llh_alu_req_t        alu_req;
  llh_alu_rsp_t        alu_rsp;
  logic [CNT_W-1:0]    mul_a;
  logic [QTL_W-1:0]    mul_b;
  logic [NQ_W-1:0]     mul_y;
  logic                ram_clr;
  logic [IDX_W-1:0]    ram_rd_addr;
  logic [CNT_W-1:0]    ram_rd_data;
  logic                ram_wr_en;
  logic [CNT_W-1:0]    ram_wr_data;
  logic [SMP_IDX_W-1:0] bkt6;
  logic [IDX_W-1:0]    bkt_c;
  logic [ACC_W-1:0]    acc_sum;
  logic                cfg_wr;
  logic                emit;

  // Shared arithmetic and memory.
  llh_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  llh_bucket_ram #(
    .DEPTH (BUCKETS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (ram_clr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (bkt_r),
    .wr_data (ram_wr_data)
  );

  // One small multiplier, shared by the target product and bucket scaling.
  assign mul_y = {{QTL_W{1'b0}}, mul_a} * {{CNT_W{1'b0}}, mul_b};

  // Bucket of the recorded sample, clamped to the last bucket.
  assign bkt6  = {byte_idx_r, msb_bit(byte_r)};
  assign bkt_c = ({1'b0, bkt6} > LAST_BKT) ? LAST_BKT[IDX_W-1:0] : bkt6[IDX_W-1:0];

  assign ram_rd_addr = (state_r == S_MAX) ? bkt_c : idx_r;
  assign acc_sum     = alu_rsp.y[ACC_W-1:0];

  // Configuration transfer.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[3] == LLH_REG_LIMIT) ? limit_r : '0;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    smp_nxt       = smp_r;
    qtl_nxt       = qtl_r;
    limit_nxt     = limit_r;
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    count_nxt     = count_r;
    byte_idx_nxt  = byte_idx_r;
    byte_nxt      = byte_r;
    bkt_nxt       = bkt_r;
    idx_nxt       = idx_r;
    nq_nxt        = nq_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    pct_idx_nxt   = pct_idx_r;
    pct_zero_nxt  = pct_zero_r;
    floor_nxt     = floor_r;
    lcnt_nxt      = lcnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    alu_req       = '0;
    mul_a         = count_r;
    mul_b         = qtl_r;
    ram_clr       = 1'b0;
    ram_wr_en     = 1'b0;
    ram_wr_data   = alu_rsp.y[CNT_W-1:0];
    emit          = 1'b0;

    if (cfg_wr && (paddr[3] == LLH_REG_LIMIT)) begin
      limit_nxt = pwdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          smp_nxt = in_data.sample_cycles;
          qtl_nxt = in_data.quantile_permille;
          unique case (in_data.operation)
            OP_RECORD: state_nxt = S_LOD;
            OP_QUERY:  state_nxt = S_QSET;
            OP_CLEAR: begin
              ram_clr   = 1'b1;
              sum_nxt   = '0;
              max_nxt   = '0;
              count_nxt = '0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Record: wrapping sum, and locate the top nonzero byte.
      S_LOD: begin
        alu_req.a    = sum_r;
        alu_req.b    = smp_r;
        sum_nxt      = alu_rsp.y;
        byte_idx_nxt = msb_byte(smp_r);
        byte_nxt     = smp_r[{msb_byte(smp_r), 3'b000} +: 8];
        state_nxt    = S_MAX;
      end

      // Record: running maximum; read the sample's bucket.
      S_MAX: begin
        alu_req.sub = 1'b1;
        alu_req.a   = max_r;
        alu_req.b   = smp_r;
        if (!alu_rsp.co) begin
          max_nxt = smp_r;
        end
        bkt_nxt   = bkt_c;
        state_nxt = S_INC;
      end

      // Record: saturating bucket increment.
      S_INC: begin
        alu_req.a = ALU_W'(ram_rd_data);
        alu_req.b = ALU_W'(1);
        ram_wr_en = (ram_rd_data != CNT_MAX);
        state_nxt = S_CNT;
      end

      // Record: saturating sample count.
      S_CNT: begin
        alu_req.a = ALU_W'(count_r);
        alu_req.b = ALU_W'(1);
        if (count_r != CNT_MAX) begin
          count_nxt = alu_rsp.y[CNT_W-1:0];
        end
        state_nxt = S_IDLE;
      end

      // Query: target product n*q; the walk compares the running sum of 1000*count against it.
      S_QSET: begin
        nq_nxt   = mul_y;
        acc_nxt  = '0;
        idx_nxt  = '0;
        lcnt_nxt = '0;
        if (count_r == '0) begin
          pct_zero_nxt = 1'b1;
          state_nxt    = S_LSET;
        end else begin
          pct_zero_nxt = 1'b0;
          state_nxt    = S_PRD;
        end
      end

      S_PRD: begin
        state_nxt = S_PMUL;
      end

      S_PMUL: begin
        mul_a     = ram_rd_data;
        mul_b     = PERMILLE_SCALE;
        prod_nxt  = mul_y;
        state_nxt = S_PACC;
      end

      // Query: running total reaches the target, or the last bucket is hit.
      S_PACC: begin
        alu_req.a = ALU_W'(acc_r);
        alu_req.b = ALU_W'(prod_r);
        acc_nxt   = acc_sum;
        if ((acc_sum >= ACC_W'(nq_r)) || (idx_r == LAST_IDX)) begin
          pct_idx_nxt = idx_r;
          state_nxt   = S_LSET;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PRD;
        end
      end

      // Query: start the above-limit walk, skipped when the limit is zero.
      S_LSET: begin
        idx_nxt   = '0;
        floor_nxt = 64'd1;
        if (limit_r == '0) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LRD;
        end
      end

      S_LRD: begin
        state_nxt = S_LACC;
      end

      // Query: add buckets whose floor exceeds the limit.
      S_LACC: begin
        alu_req.a = ALU_W'(lcnt_r);
        alu_req.b = ALU_W'(ram_rd_data);
        if (floor_r > limit_r) begin
          lcnt_nxt = alu_rsp.y[LCNT_W-1:0];
        end
        floor_nxt = floor_r << 1;
        if (idx_r == LAST_IDX) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LRD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Result formation at the end of a query.
    if (emit) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.percentile_floor = pct_zero_r ? '0 : (SAMPLE_W'(1) << pct_idx_r);
      out_data_nxt.count_above_limit = (|lcnt_nxt[LCNT_W-1:CNT_W]) ?
                                       CNT_MAX : lcnt_nxt[CNT_W-1:0];
      out_data_nxt.total_samples    = count_r;
      out_data_nxt.sample_sum       = sum_r;
      out_data_nxt.largest_sample   = max_r;
    end
  end

  // Control and statistics registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= '0;
      sum_r       <= '0;
      max_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    qtl_r      <= qtl_nxt;
    byte_idx_r <= byte_idx_nxt;
    byte_r     <= byte_nxt;
    bkt_r      <= bkt_nxt;
    idx_r      <= idx_nxt;
    nq_r       <= nq_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    pct_idx_r  <= pct_idx_nxt;
    pct_zero_r <= pct_zero_nxt;
    floor_r    <= floor_nxt;
    lcnt_r     <= lcnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== src/llh_alu.sv =====
// ----------------------------------------------------------------------------
// llh_alu
// Shared 64-bit adder/subtractor. The sums, counter increments and running-maximum
// compare of the histogram sequencer go through this one unit.
// ----------------------------------------------------------------------------
module llh_alu
  import llh_pkg::*;
(
  input  llh_alu_req_t req,
  output llh_alu_rsp_t rsp
);

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   full;

  // Subtract is a + ~b + 1; the carry out then means a >= b.
  assign b_op  = req.sub ? ~req.b : req.b;
  assign full  = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};
  assign rsp.y  = full[ALU_W-1:0];
  assign rsp.co = full[ALU_W];

endmodule

// ===== src/llh_bucket_ram.sv =====
// ----------------------------------------------------------------------------
// llh_bucket_ram
// Bucket counter memory: one write port, one registered read port. A valid
// bit per entry makes reset and the clear operation take effect at once;
// an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module llh_bucket_ram
  import llh_pkg::*;
#(
  parameter int DEPTH = LLH_BUCKETS,
  parameter int IDX_W = $clog2(LLH_BUCKETS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [CNT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [CNT_W-1:0] wr_data
);

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [CNT_W-1:0] mem_rd_r;
  logic             rd_vld_r;

  // Storage array: write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  // Valid bits, cleared together by reset or a clear operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? mem_rd_r : '0;

endmodule
